/* hdl/bpm_pkg.sv */
package bpm_pkg;

	// fixed widths of the register and the words
	localparam int SIZE_W = 7;
	localparam int ROW_W  = 64;

	// search sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_ROW,
		ST_LDROW,
		ST_STEP,
		ST_LDSTK,
		ST_OWN,
		ST_AUGRD,
		ST_AUGWR,
		ST_DONE
	} st_t;

endpackage

/* hdl/bpm_row_if.sv */
interface bpm_row_if;
	import bpm_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_bits;

	modport source (output valid, output row_bits, input ready);
	modport sink   (input valid, input row_bits, output ready);
endinterface

/* hdl/bpm_res_if.sv */
interface bpm_res_if;
	logic valid;
	logic ready;
	logic match_found;

	modport source (output valid, output match_found, input ready);
	modport sink   (input valid, input match_found, output ready);
endinterface

/* hdl/bipartite_perfect_match_check_unit.sv */
// Perfect matching check for a square bit relation of up to MAX_SET by MAX_SET.
// row_in  : one relation row per word, row 0 first; bits at or above set_size
//           are dropped. While rows load the block takes one word a cycle.
// res_out : one word per relation, match_found high when every row can be
//           paired with a distinct related column.
// cfg_we / cfg_wdata : write set_size (0 acts as 1, above MAX_SET as MAX_SET);
//           a write restarts loading at row 0.
// After the last row the block runs an augmenting-path search and is not ready.
// The sequencer starts each new row through ROW and LDROW, tries one column
// per STEP, steps down into the owner of a taken column through OWN and LDROW,
// steps back through LDSTK, and augments a path with AUGRD and AUGWR per level.
// The run time is data dependent; the registered reads of the row, stack and
// path memories set its pace.
// Reset leaves set_size at 1, no rows loaded and no word pending on res_out.
// A result waits in an output register; loading of the next relation goes on
// meanwhile, and only its last row is held off until the result is taken.
module bipartite_perfect_match_check_unit #(
	parameter int MAX_SET = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bpm_row_if.sink                    row_in,
	bpm_res_if.source                  res_out,
	input  logic                       cfg_we,
	input  logic [bpm_pkg::SIZE_W-1:0] cfg_wdata
);
	import bpm_pkg::*;

	localparam int IDX_W = $clog2(MAX_SET);

	// control state
	st_t               st_q, st_nxt;
	logic [SIZE_W-1:0] set_size_q;
	logic [SIZE_W-1:0] rows_loaded_q;
	logic [IDX_W-1:0]  r_q;
	logic [IDX_W-1:0]  lvl_q;
	logic              ok_q;
	logic              out_valid_q;
	logic              out_match_q;

	// search datapath
	logic [MAX_SET-1:0] free_q;
	logic [MAX_SET-1:0] vis_q;
	logic [MAX_SET-1:0] cur_q;

	// memories and their registered read data
	logic [MAX_SET-1:0] row_mem [MAX_SET];
	logic [MAX_SET-1:0] stk_mem [MAX_SET];
	logic [IDX_W-1:0]   prow_mem [MAX_SET];
	logic [IDX_W-1:0]   pcol_mem [MAX_SET];
	logic [IDX_W-1:0]   own_mem [MAX_SET];
	logic [MAX_SET-1:0] row_rd_q;
	logic [MAX_SET-1:0] stk_rd_q;
	logic [IDX_W-1:0]   prow_rd_q;
	logic [IDX_W-1:0]   pcol_rd_q;
	logic [IDX_W-1:0]   own_rd_q;

	logic [SIZE_W-1:0]  n_eff;
	logic [SIZE_W-1:0]  n_m1;
	logic [MAX_SET-1:0] col_mask;
	logic [SIZE_W-1:0]  load_idx;
	logic               last_row;
	logic               in_acc;
	logic [MAX_SET-1:0] cand;
	logic               cand_none;
	logic [MAX_SET-1:0] onehot;
	logic [IDX_W-1:0]   c_idx;
	logic               hit_free;
	logic               lvl_zero;
	logic               r_last;

	// memory port controls
	logic               row_re_sel;
	logic [IDX_W-1:0]   row_raddr;
	logic [IDX_W-1:0]   stk_raddr;
	logic               stk_we;
	logic               prow_we;
	logic [IDX_W-1:0]   prow_waddr;
	logic [IDX_W-1:0]   prow_wdata;
	logic               pcol_we;
	logic               own_we;

	// effective size and column mask
	always_comb begin
		if (set_size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (set_size_q > SIZE_W'(MAX_SET)) begin
			n_eff = SIZE_W'(MAX_SET);
		end else begin
			n_eff = set_size_q;
		end
		n_m1 = n_eff - SIZE_W'(1);
		for (int j = 0; j < MAX_SET; j++) begin
			col_mask[j] = SIZE_W'(j) < n_eff;
		end
	end

	// row loading
	assign load_idx = (rows_loaded_q >= n_eff) ? '0 : rows_loaded_q;
	assign last_row = load_idx >= n_m1;
	assign row_in.ready = (st_q == ST_LOAD) && !(out_valid_q && last_row);
	assign in_acc = row_in.valid && row_in.ready;

	// lowest untried column of the current level
	assign cand      = cur_q & ~vis_q;
	assign cand_none = cand == '0;
	assign onehot    = cand & (~cand + MAX_SET'(1));
	always_comb begin
		c_idx = '0;
		for (int j = 0; j < MAX_SET; j++) begin
			if (onehot[j]) begin
				c_idx = c_idx | IDX_W'(j);
			end
		end
	end
	assign hit_free = |(free_q & onehot);
	assign lvl_zero = lvl_q == '0;
	assign r_last   = SIZE_W'(r_q) == n_m1;

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_LOAD:  if (in_acc && last_row) st_nxt = ST_INIT;
			ST_INIT:  st_nxt = ST_ROW;
			ST_ROW:   st_nxt = ST_LDROW;
			ST_LDROW: st_nxt = ST_STEP;
			ST_STEP: begin
				priority if (cand_none && lvl_zero) st_nxt = ST_DONE;
				else if (cand_none)                 st_nxt = ST_LDSTK;
				else if (hit_free)                  st_nxt = ST_AUGRD;
				else                                st_nxt = ST_OWN;
			end
			ST_LDSTK: st_nxt = ST_STEP;
			ST_OWN:   st_nxt = ST_LDROW;
			ST_AUGRD: st_nxt = ST_AUGWR;
			ST_AUGWR: begin
				priority if (!lvl_zero) st_nxt = ST_AUGRD;
				else if (r_last)        st_nxt = ST_DONE;
				else                    st_nxt = ST_ROW;
			end
			ST_DONE:  st_nxt = ST_LOAD;
			default:  st_nxt = ST_LOAD;
		endcase
	end

	// memory port controls
	always_comb begin
		row_re_sel = 1'b0;
		stk_we     = 1'b0;
		prow_we    = 1'b0;
		prow_waddr = lvl_q;
		prow_wdata = r_q;
		pcol_we    = 1'b0;
		own_we     = 1'b0;
		stk_raddr  = lvl_q - IDX_W'(1);
		unique case (st_q)
			ST_ROW: begin
				prow_we    = 1'b1;
				prow_waddr = '0;
			end
			ST_STEP: begin
				stk_we  = !cand_none;
				pcol_we = !cand_none;
			end
			ST_OWN: begin
				row_re_sel = 1'b1;
				prow_we    = 1'b1;
				prow_waddr = lvl_q + IDX_W'(1);
				prow_wdata = own_rd_q;
			end
			ST_AUGWR: own_we = 1'b1;
			default: ;
		endcase
		row_raddr = row_re_sel ? own_rd_q : r_q;
	end

	// relation rows
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_mem[load_idx[IDX_W-1:0]] <= row_in.row_bits[MAX_SET-1:0] & col_mask;
		end
		row_rd_q <= row_mem[row_raddr];
	end

	// untried columns per level
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[lvl_q] <= cand & ~onehot;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// path rows
	always_ff @(posedge clk) begin
		if (prow_we) begin
			prow_mem[prow_waddr] <= prow_wdata;
		end
		prow_rd_q <= prow_mem[lvl_q];
	end

	// path columns
	always_ff @(posedge clk) begin
		if (pcol_we) begin
			pcol_mem[lvl_q] <= c_idx;
		end
		pcol_rd_q <= pcol_mem[lvl_q];
	end

	// owner row of each taken column
	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[pcol_rd_q] <= prow_rd_q;
		end
		own_rd_q <= own_mem[c_idx];
	end

	// search datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_INIT:  free_q <= col_mask;
			ST_ROW:   vis_q  <= '0;
			ST_LDROW: cur_q  <= row_rd_q;
			ST_LDSTK: cur_q  <= stk_rd_q;
			ST_STEP: begin
				if (!cand_none) begin
					cur_q <= cand & ~onehot;
					vis_q <= vis_q | onehot;
					if (hit_free) begin
						free_q <= free_q & ~onehot;
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_LOAD;
			set_size_q    <= SIZE_W'(1);
			rows_loaded_q <= '0;
			r_q           <= '0;
			lvl_q         <= '0;
			ok_q          <= 1'b0;
			out_valid_q   <= 1'b0;
			out_match_q   <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_we) begin
				set_size_q    <= cfg_wdata;
				rows_loaded_q <= '0;
			end else if (in_acc) begin
				rows_loaded_q <= last_row ? '0 : load_idx + SIZE_W'(1);
			end
			if (res_out.valid && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_INIT: begin
					r_q  <= '0;
					ok_q <= 1'b1;
				end
				ST_ROW: lvl_q <= '0;
				ST_STEP: begin
					if (cand_none && lvl_zero) begin
						ok_q <= 1'b0;
					end else if (cand_none) begin
						lvl_q <= lvl_q - IDX_W'(1);
					end
				end
				ST_OWN: lvl_q <= lvl_q + IDX_W'(1);
				ST_AUGWR: begin
					if (!lvl_zero) begin
						lvl_q <= lvl_q - IDX_W'(1);
					end else begin
						r_q <= r_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					out_match_q <= ok_q;
				end
				default: ;
			endcase
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.match_found = out_match_q;

endmodule
